// ===== design/etlca_pkg.sv =====
// Shared types and constants for the Euler-tour lowest-common-ancestor block.
package etlca_pkg;

	localparam int NODE_W  = 10;
	localparam int LEVEL_W = 10;

	localparam logic REQ_LOAD  = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	typedef struct packed {
		logic               req_type;
		logic               first_entry;
		logic [NODE_W-1:0]  entry_node;
		logic [LEVEL_W-1:0] entry_level;
		logic [NODE_W-1:0]  node_a;
		logic [NODE_W-1:0]  node_b;
		logic [NODE_W-1:0]  query_root;
	} req_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_UNSEEN   = 2'd1,
		ST_OVERFLOW = 2'd2
	} status_t;

	typedef struct packed {
		logic [NODE_W-1:0] ancestor_node;
		status_t           status;
	} rsp_t;

	typedef struct packed {
		logic [NODE_W-1:0]  node;
		logic [LEVEL_W-1:0] level;
	} entry_t;

	typedef enum logic [3:0] {
		OP_NONE       = 4'd0,
		OP_CLR        = 4'd1,
		OP_CAPTURE    = 4'd2,
		OP_FP_RD      = 4'd3,
		OP_TN_RD      = 4'd4,
		OP_CHECK      = 4'd5,
		OP_SCAN_START = 4'd6,
		OP_SCAN_STEP  = 4'd7,
		OP_EMIT       = 4'd8
	} op_t;

	typedef enum logic [1:0] {
		KEY_NODE = 2'd0,
		KEY_A    = 2'd1,
		KEY_B    = 2'd2,
		KEY_R    = 2'd3
	} key_t;

	typedef enum logic [1:0] {
		PAIR_AB = 2'd0,
		PAIR_AR = 2'd1,
		PAIR_BR = 2'd2
	} pair_t;

	typedef struct packed {
		op_t     op;
		key_t    key;
		pair_t   pair;
		status_t res;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic query;
		logic full;
		logic seen;
		logic root_match;
		logic scan_done;
		logic out_free;
	} stat_t;

endpackage

// ===== design/euler_tour_lca_query.sv =====
// Top level: lowest common ancestor lookup over a stored Euler tour.
//
//   channel  signals                     direction  carries
//   req      req_valid, req_ready, req   in         tour entry load or ancestor query
//   rsp      rsp_valid, rsp_ready, rsp   out        ancestor node and status
//
// A load does one read of the first-position memory, one read of the tour
// memory to confirm the node, then the append and back to ready; a load into
// a full tour gets an overflow result instead. A query takes three such
// lookups, then one scan of the tour memory per node pair at one position a
// cycle, with setup and drain around each scan and one read port the limit.
// After reset the block sweeps all MAX_NODES entries of the first-position
// memory with req_ready low. A pending result does not stop acceptance; a new
// result waits in place until the previous one is taken.
module euler_tour_lca_query import etlca_pkg::*; #(
	parameter int MAX_NODES = 1024,
	parameter int MAX_TOUR  = 2048
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	// command and status between sequencer and datapath
	cmd_t  cmd;
	stat_t stat;

	// sequencer: owns the req handshake and walks clear, lookup, scan and emit steps
	etlca_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_type  (req.req_type),
		.req_ready (req_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// datapath: memories, counters and the output register that parts the two sides
	etlca_dp #(
		.MAX_NODES (MAX_NODES),
		.MAX_TOUR  (MAX_TOUR)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.stat      (stat),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule

// ===== design/etlca_dp.sv =====
// Datapath: tour and first-position memories, node lookup, range-minimum scan, result register.
module etlca_dp import etlca_pkg::*; #(
	parameter int MAX_NODES = 1024,
	parameter int MAX_TOUR  = 2048
) (
	input  logic  clk,
	input  logic  arst_n,
	input  req_t  req,
	input  cmd_t  cmd,
	output stat_t stat,
	output logic  rsp_valid,
	input  logic  rsp_ready,
	output rsp_t  rsp
);

	localparam int NAW = $clog2(MAX_NODES);
	localparam int PW  = $clog2(MAX_TOUR);
	localparam int LW  = $clog2(MAX_TOUR + 1);

	logic [PW-1:0] fp_mem [MAX_NODES];
	entry_t        tour_mem [MAX_TOUR];

	req_t              req_q;
	logic [LW-1:0]     len_q;
	logic [NODE_W-1:0] root_q;
	logic [NAW-1:0]    clr_cnt_q;
	logic [NODE_W-1:0] key_q;
	logic              rng_q;
	logic [PW-1:0]     fp_rd_q;
	logic              lt_q;
	entry_t            tour_rd_q;
	logic [PW-1:0]     pos_a_q, pos_b_q, pos_r_q;
	logic [PW-1:0]     sc_addr_q, hi_q;
	logic              sc_busy_q, rd_vld_q, first_q;
	logic [NODE_W-1:0]  best_node_q;
	logic [LEVEL_W-1:0] best_level_q;
	logic [NODE_W-1:0] ca_q, cb_q, cc_q;
	logic              rsp_valid_q;
	rsp_t              rsp_q;

	logic [NODE_W-1:0] key_d;
	logic              rng_d;
	logic              seen;
	logic [PW-1:0]     pp, pq, lo_d, hi_d;
	logic              fp_we;
	logic [NAW-1:0]    fp_waddr;
	logic [PW-1:0]     fp_wdata;
	logic              tour_re;
	logic [PW-1:0]     tour_raddr;
	logic              scan_done;
	logic [NODE_W-1:0] odd;

	always_comb begin
		case (cmd.key)
			KEY_NODE: key_d = req_q.entry_node;
			KEY_A:    key_d = req_q.node_a;
			KEY_B:    key_d = req_q.node_b;
			KEY_R:    key_d = req_q.query_root;
			default:  key_d = req_q.entry_node;
		endcase
	end

	assign rng_d = 32'(key_d) < 32'(MAX_NODES);
	assign seen  = rng_q && lt_q && (tour_rd_q.node == key_q);

	always_comb begin
		case (cmd.pair)
			PAIR_AB: begin pp = pos_a_q; pq = pos_b_q; end
			PAIR_AR: begin pp = pos_a_q; pq = pos_r_q; end
			PAIR_BR: begin pp = pos_b_q; pq = pos_r_q; end
			default: begin pp = pos_a_q; pq = pos_b_q; end
		endcase
	end

	assign lo_d = (pp < pq) ? pp : pq;
	assign hi_d = (pp < pq) ? pq : pp;

	assign scan_done = !sc_busy_q && !rd_vld_q;

	// first-position write port: clearing sweep or first sight of a node
	always_comb begin
		fp_we    = 1'b0;
		fp_waddr = clr_cnt_q;
		fp_wdata = '1;
		if (cmd.op == OP_CLR) begin
			fp_we = 1'b1;
		end else if (cmd.op == OP_CHECK && req_q.req_type == REQ_LOAD && rng_q && !seen) begin
			fp_we    = 1'b1;
			fp_waddr = NAW'(key_q);
			fp_wdata = len_q[PW-1:0];
		end
	end

	assign tour_re    = (cmd.op == OP_TN_RD) || (cmd.op == OP_SCAN_STEP && sc_busy_q);
	assign tour_raddr = (cmd.op == OP_TN_RD) ? fp_rd_q : sc_addr_q;

	always_ff @(posedge clk) begin
		if (fp_we) begin
			fp_mem[fp_waddr] <= fp_wdata;
		end
		if (cmd.op == OP_FP_RD) begin
			fp_rd_q <= fp_mem[NAW'(key_d)];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_CHECK && req_q.req_type == REQ_LOAD) begin
			tour_mem[len_q[PW-1:0]] <= '{node: req_q.entry_node, level: req_q.entry_level};
		end
		if (tour_re) begin
			tour_rd_q <= tour_mem[tour_raddr];
		end
	end

	// odd one out of the three candidates; pair (a,b) alone when the root is the stored one
	always_comb begin
		if (stat.root_match)   odd = ca_q;
		else if (ca_q == cb_q) odd = cc_q;
		else if (ca_q == cc_q) odd = cb_q;
		else                   odd = ca_q;
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_CAPTURE: req_q <= req;
			OP_FP_RD: begin
				key_q <= key_d;
				rng_q <= rng_d;
			end
			OP_TN_RD: lt_q <= LW'(fp_rd_q) < len_q;
			OP_CHECK: begin
				case (cmd.key)
					KEY_A:   pos_a_q <= fp_rd_q;
					KEY_B:   pos_b_q <= fp_rd_q;
					KEY_R:   pos_r_q <= fp_rd_q;
					default: ;
				endcase
			end
			OP_SCAN_START: begin
				sc_addr_q <= lo_d;
				hi_q      <= hi_d;
			end
			OP_SCAN_STEP: begin
				if (sc_busy_q && sc_addr_q != hi_q) begin
					sc_addr_q <= sc_addr_q + 1'b1;
				end
				if (rd_vld_q && (first_q || tour_rd_q.level < best_level_q)) begin
					best_node_q  <= tour_rd_q.node;
					best_level_q <= tour_rd_q.level;
				end
				if (scan_done) begin
					case (cmd.pair)
						PAIR_AB: ca_q <= best_node_q;
						PAIR_AR: cb_q <= best_node_q;
						PAIR_BR: cc_q <= best_node_q;
						default: ;
					endcase
				end
			end
			OP_EMIT: begin
				rsp_q.ancestor_node <= (cmd.res == ST_OK) ? odd : '0;
				rsp_q.status        <= cmd.res;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q       <= '0;
			root_q      <= '0;
			clr_cnt_q   <= '0;
			sc_busy_q   <= 1'b0;
			rd_vld_q    <= 1'b0;
			first_q     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.op == OP_CLR) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
			end
			if (cmd.op == OP_CAPTURE && req.req_type == REQ_LOAD && req.first_entry) begin
				len_q  <= '0;
				root_q <= req.entry_node;
			end
			if (cmd.op == OP_CHECK && req_q.req_type == REQ_LOAD) begin
				len_q <= len_q + 1'b1;
			end
			if (cmd.op == OP_SCAN_START) begin
				sc_busy_q <= 1'b1;
				rd_vld_q  <= 1'b0;
				first_q   <= 1'b1;
			end else if (cmd.op == OP_SCAN_STEP) begin
				rd_vld_q <= sc_busy_q;
				if (sc_busy_q && sc_addr_q == hi_q) begin
					sc_busy_q <= 1'b0;
				end
				if (rd_vld_q) begin
					first_q <= 1'b0;
				end
			end
			if (cmd.op == OP_EMIT) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign stat.clr_last   = clr_cnt_q == NAW'(MAX_NODES - 1);
	assign stat.query      = req_q.req_type == REQ_QUERY;
	assign stat.full       = len_q == LW'(MAX_TOUR);
	assign stat.seen       = seen;
	assign stat.root_match = req_q.query_root == root_q;
	assign stat.scan_done  = scan_done;
	assign stat.out_free   = !rsp_valid_q || rsp_ready;

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LW'(MAX_TOUR))
		else $error("tour length beyond capacity");

	a_len_step: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_CHECK && req_q.req_type == REQ_LOAD) |=> len_q == LW'($past(len_q) + 1'b1))
		else $error("tour length did not advance on append");

	a_rsp_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(cmd.op == OP_EMIT))
		else $error("result raised without emit command");

endmodule

// ===== design/etlca_ctrl.sv =====
// Controller: sequences clear sweep, node lookups, range scans and result hand-off.
module etlca_ctrl import etlca_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  req_valid,
	input  logic  req_type,
	output logic  req_ready,
	input  stat_t stat,
	output cmd_t  cmd
);

	typedef enum logic [7:0] {
		S_CLEAR = 8'b0000_0001,
		S_IDLE  = 8'b0000_0010,
		S_FP    = 8'b0000_0100,
		S_TN    = 8'b0000_1000,
		S_CHK   = 8'b0001_0000,
		S_START = 8'b0010_0000,
		S_SCAN  = 8'b0100_0000,
		S_EMIT  = 8'b1000_0000
	} state_t;

	state_t  state_q, state_d;
	key_t    key_q, key_d;
	pair_t   pair_q, pair_d;
	status_t res_q, res_d;
	op_t     op;

	always_comb begin
		state_d = state_q;
		key_d   = key_q;
		pair_d  = pair_q;
		res_d   = res_q;
		op      = OP_NONE;
		case (state_q)
			S_CLEAR: begin
				op = OP_CLR;
				if (stat.clr_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (req_valid) begin
					op      = OP_CAPTURE;
					key_d   = (req_type == REQ_LOAD) ? KEY_NODE : KEY_A;
					pair_d  = PAIR_AB;
					state_d = S_FP;
				end
			end
			S_FP: begin
				if (!stat.query && stat.full) begin
					res_d   = ST_OVERFLOW;
					state_d = S_EMIT;
				end else begin
					op      = OP_FP_RD;
					state_d = S_TN;
				end
			end
			S_TN: begin
				op      = OP_TN_RD;
				state_d = S_CHK;
			end
			S_CHK: begin
				op = OP_CHECK;
				if (!stat.query) begin
					state_d = S_IDLE;
				end else if (!stat.seen) begin
					res_d   = ST_UNSEEN;
					state_d = S_EMIT;
				end else if (key_q == KEY_R) begin
					state_d = S_START;
				end else begin
					key_d   = (key_q == KEY_A) ? KEY_B : KEY_R;
					state_d = S_FP;
				end
			end
			S_START: begin
				op      = OP_SCAN_START;
				state_d = S_SCAN;
			end
			S_SCAN: begin
				op = OP_SCAN_STEP;
				if (stat.scan_done) begin
					if (pair_q == PAIR_BR || (pair_q == PAIR_AB && stat.root_match)) begin
						res_d   = ST_OK;
						state_d = S_EMIT;
					end else begin
						pair_d  = (pair_q == PAIR_AB) ? PAIR_AR : PAIR_BR;
						state_d = S_START;
					end
				end
			end
			S_EMIT: begin
				if (stat.out_free) begin
					op      = OP_EMIT;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			key_q   <= KEY_NODE;
			pair_q  <= PAIR_AB;
			res_q   <= ST_OK;
		end else begin
			state_q <= state_d;
			key_q   <= key_d;
			pair_q  <= pair_d;
			res_q   <= res_d;
		end
	end

	assign req_ready = state_q == S_IDLE;
	assign cmd.op    = op;
	assign cmd.key   = key_q;
	assign cmd.pair  = pair_q;
	assign cmd.res   = res_q;

	a_accept_seq: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> state_q == S_FP)
		else $error("accepted item did not start lookup");

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_EMIT |-> stat.out_free)
		else $error("result overwritten before it was taken");

	a_scan_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN && !stat.scan_done) |=> state_q == S_SCAN)
		else $error("scan abandoned before completion");

endmodule
